/* src/hcr_pkg.sv */
`default_nettype none
package hcr_pkg;

	// Item command codes.
	localparam logic [1:0] CMD_WRITE_STOP = 2'd0;
	localparam logic [1:0] CMD_BUILD      = 2'd1;
	localparam logic [1:0] CMD_SAMPLE     = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_TABLE_RES  = 2'd0;
	localparam logic [1:0] REG_STOP_COUNT = 2'd1;

	// Fixed-point constants.
	localparam logic [16:0] Q16_ONE   = 17'h10000;
	localparam logic [10:0] RES_RESET = 11'd1024;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic stop_wr;
		logic bld_start;
		logic smp_start;
		logic stop_rd;
		logic mul_stop;
		logic next_stop;
		logic row_black;
		logic row_first;
		logic interp_init;
		logic mul1;
		logic mul2;
		logic div_start;
		logic chan_store;
		logic row_write;
		logic next_row;
		logic mark_built;
		logic smp_mul;
		logic smp_rd;
		logic lerp;
		logic out_load;
	} hcr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic j_zero;
		logic last_stop;
		logic no_stops;
		logic last_row;
		logic last_chan;
		logic div_done;
		logic out_busy;
	} hcr_sts_t;

endpackage
`default_nettype wire

/* src/hcr_divider.sv */
`default_nettype none
module hcr_divider #(
	parameter int NW = 45,
	parameter int DW = 30,
	parameter int QW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [QW-1:0]      quot
);
	localparam int CW = (QW > 1) ? $clog2(QW) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [QW-1:0] quot_q;
	logic          ge;

	assign ge   = rem_q >= dsh_q;
	assign done = done_q;
	assign quot = quot_q;

	// Control: one quotient bit per cycle, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Restoring shift and subtract.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= NW'(den) << (QW - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

endmodule
`default_nettype wire

/* src/hcr_datapath.sv */
`default_nettype none
module hcr_datapath #(
	parameter int MAX_STOPS    = 8,
	parameter int TABLE_DEPTH  = 1024,
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hcr_pkg::hcr_cmd_t cmd,
	output hcr_pkg::hcr_sts_t     sts,
	input  wire logic             cfg_valid,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [10:0]      cfg_data,
	input  wire logic [2:0]       stop_index,
	input  wire logic [16:0]      stop_pos,
	input  wire logic [15:0]      stop_red,
	input  wire logic [15:0]      stop_green,
	input  wire logic [15:0]      stop_blue,
	input  wire logic [17:0]      sample_value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [15:0]           red,
	output logic [15:0]           green,
	output logic [15:0]           blue
);
	import hcr_pkg::*;

	localparam int CB    = CHANNEL_BITS;
	localparam int RES_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SA_W  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int SJ_W  = $clog2(MAX_STOPS + 1);
	localparam int PW    = 17 + RES_W;
	localparam int NW    = CB + PW;
	localparam int LW    = CB + 19;
	localparam logic signed [LW-1:0] HALF = LW'(32768);

	typedef logic [2:0][CB-1:0] col_t;

	// Configuration registers.
	logic [10:0] table_res_q;
	logic [3:0]  stop_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_res_q  <= RES_RESET;
			stop_count_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TABLE_RES) begin
				table_res_q <= cfg_data;
			end else if (cfg_index == REG_STOP_COUNT) begin
				stop_count_q <= cfg_data[3:0];
			end
		end
	end

	// Stop memory, one read port with registered data.
	logic [16:0]   pos_mem [MAX_STOPS];
	col_t          col_mem [MAX_STOPS];
	logic [16:0]   rd_pos_q;
	col_t          rd_col_q;
	logic [31:0]   widx;
	logic [SJ_W-1:0] j_q;

	assign widx = 32'(stop_index);

	always_ff @(posedge clk) begin
		if (cmd.stop_wr && (widx < 32'(MAX_STOPS))) begin
			pos_mem[widx[SA_W-1:0]] <= stop_pos;
			col_mem[widx[SA_W-1:0]] <= {stop_red[CB-1:0], stop_green[CB-1:0], stop_blue[CB-1:0]};
		end
		if (cmd.stop_rd) begin
			rd_pos_q <= pos_mem[j_q[SA_W-1:0]];
			rd_col_q <= col_mem[j_q[SA_W-1:0]];
		end
	end

	// Build settings taken when a build starts; they also serve later samples.
	logic [31:0]      tr_w;
	logic [31:0]      sc_w;
	logic [RES_W-1:0] res_w;
	logic [SJ_W-1:0]  n_w;
	logic [RES_W-1:0] bres_q;
	logic [SJ_W-1:0]  n_q;
	logic             built_q;

	always_comb begin
		tr_w = 32'(table_res_q);
		sc_w = 32'(stop_count_q);
		if (tr_w < 32'd2) begin
			res_w = RES_W'(2);
		end else if (tr_w > 32'(TABLE_DEPTH)) begin
			res_w = RES_W'(TABLE_DEPTH);
		end else begin
			res_w = tr_w[RES_W-1:0];
		end
		if (sc_w > 32'(MAX_STOPS)) begin
			n_w = SJ_W'(MAX_STOPS);
		end else begin
			n_w = sc_w[SJ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q <= 1'b0;
			bres_q  <= '0;
		end else begin
			if (cmd.bld_start) begin
				bres_q <= res_w;
			end
			if (cmd.mark_built) begin
				built_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bld_start) begin
			n_q <= n_w;
		end
	end

	// Row and stop counters of the build, and the channel counter shared with sampling.
	logic [IDX_W-1:0] i_q;
	logic [1:0]       chan_q;
	logic [PW-1:0]    target;
	logic [PW-1:0]    prod_q;
	logic [PW-1:0]    prev_prod_q;
	col_t             cur_col_q;
	col_t             prev_col_q;
	col_t             row_col_q;
	logic [PW-1:0]    num_q;
	logic [PW-1:0]    den_q;
	logic [NW-1:0]    t1_q;
	logic [NW-1:0]    nsum_q;
	logic             div_done;
	logic [CB-1:0]    div_quot;

	assign target = PW'({i_q, 16'h0000});

	always_ff @(posedge clk) begin
		if (cmd.bld_start || cmd.next_row) begin
			j_q <= '0;
		end else if (cmd.next_stop) begin
			j_q <= j_q + 1'b1;
		end
		if (cmd.bld_start) begin
			i_q <= '0;
		end else if (cmd.next_row) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.interp_init || cmd.smp_rd) begin
			chan_q <= '0;
		end else if (cmd.chan_store || cmd.lerp) begin
			chan_q <= chan_q + 1'b1;
		end
	end

	// Stop scan: position times resolution against the row target.
	always_ff @(posedge clk) begin
		if (cmd.mul_stop) begin
			prod_q    <= PW'(rd_pos_q) * PW'(bres_q);
			cur_col_q <= rd_col_q;
		end
		if (cmd.next_stop) begin
			prev_prod_q <= prod_q;
			prev_col_q  <= cur_col_q;
		end
		if (cmd.interp_init) begin
			num_q <= target - prev_prod_q;
			den_q <= prod_q - prev_prod_q;
		end
	end

	// Interpolation numerator, one channel at a time.
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			t1_q <= NW'(prev_col_q[chan_q]) * NW'(den_q - num_q);
		end
		if (cmd.mul2) begin
			nsum_q <= t1_q + NW'(cur_col_q[chan_q]) * NW'(num_q) + NW'(den_q >> 1);
		end
		if (cmd.row_black) begin
			row_col_q <= '0;
		end else if (cmd.row_first) begin
			row_col_q <= cur_col_q;
		end else if (cmd.chan_store) begin
			row_col_q[chan_q] <= div_quot;
		end
	end

	hcr_divider #(
		.NW(NW),
		.DW(PW),
		.QW(CB)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (nsum_q),
		.den   (den_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Sample front end: clamp and scale.
	logic [17:0]      smp_q;
	logic [16:0]      x_w;
	logic [PW-1:0]    pos_s1;
	logic [RES_W:0]   k_w;
	logic [RES_W:0]   last_w;
	logic             at_end;
	logic [IDX_W-1:0] ka_w;
	logic [IDX_W-1:0] kb_w;
	logic [15:0]      f_w;
	logic [15:0]      f_q;

	always_comb begin
		if (smp_q[17]) begin
			x_w = '0;
		end else if (smp_q[16] && (smp_q[15:0] != 16'h0000)) begin
			x_w = Q16_ONE;
		end else begin
			x_w = smp_q[16:0];
		end
		k_w    = pos_s1[PW-1:16];
		last_w = (RES_W + 1)'(bres_q) - 1'b1;
		at_end = k_w >= last_w;
		if (at_end) begin
			ka_w = last_w[IDX_W-1:0];
			kb_w = last_w[IDX_W-1:0];
			f_w  = '0;
		end else begin
			ka_w = k_w[IDX_W-1:0];
			kb_w = k_w[IDX_W-1:0] + 1'b1;
			f_w  = pos_s1[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.smp_start) begin
			smp_q <= sample_value;
		end
		if (cmd.smp_mul) begin
			pos_s1 <= PW'(x_w) * PW'(bres_q);
		end
		if (cmd.smp_rd) begin
			f_q <= f_w;
		end
	end

	// Color table: one write port, two registered read ports.
	col_t tbl_mem [TABLE_DEPTH];
	col_t ta_q;
	col_t tb_q;

	always_ff @(posedge clk) begin
		if (cmd.row_write) begin
			tbl_mem[i_q] <= row_col_q;
		end
		if (cmd.smp_rd) begin
			ta_q <= tbl_mem[ka_w];
			tb_q <= tbl_mem[kb_w];
		end
	end

	// Linear blend between adjacent entries: a + round((b - a) * f / 65536).
	logic signed [CB:0]    d_w;
	logic signed [16:0]    fs_w;
	logic signed [LW-1:0]  lp_w;
	logic signed [LW-1:0]  lr_w;
	logic [LW-1:0]         sum_w;
	col_t                  res_col_q;

	always_comb begin
		d_w   = $signed({1'b0, tb_q[chan_q]}) - $signed({1'b0, ta_q[chan_q]});
		fs_w  = $signed({1'b0, f_q});
		lp_w  = LW'(d_w) * LW'(fs_w);
		lr_w  = (lp_w + HALF) >>> 16;
		sum_w = LW'({1'b0, ta_q[chan_q]}) + lr_w;
	end

	always_ff @(posedge clk) begin
		if (cmd.lerp) begin
			res_col_q[chan_q] <= sum_w[CB-1:0];
		end
	end

	// Output register.
	logic          out_valid_q;
	logic [15:0]   red_q;
	logic [15:0]   green_q;
	logic [15:0]   blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_q   <= built_q ? 16'(res_col_q[2]) : 16'h0000;
			green_q <= built_q ? 16'(res_col_q[1]) : 16'h0000;
			blue_q  <= built_q ? 16'(res_col_q[0]) : 16'h0000;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

	// Status toward the controller.
	always_comb begin
		sts.hit       = prod_q >= target;
		sts.j_zero    = j_q == '0;
		sts.last_stop = ({1'b0, j_q} + 1'b1) >= {1'b0, n_q};
		sts.no_stops  = n_q == '0;
		sts.last_row  = RES_W'(i_q) == (bres_q - 1'b1);
		sts.last_chan = chan_q == 2'd2;
		sts.div_done  = div_done;
		sts.out_busy  = out_valid_q && !out_ready;
	end

`ifndef SYNTHESIS
	a_out_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result register not marked valid after load");
	a_mul_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_stop |-> $past(cmd.stop_rd))
		else $error("stop product taken without a preceding stop read");
	a_write_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.row_black, cmd.row_first, cmd.chan_store}))
		else $error("row color set from two sources at once");
`endif

endmodule
`default_nettype wire

/* src/hcr_ctrl.sv */
`default_nettype none
module hcr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        in_cmd,
	output logic                   in_ready,
	input  wire hcr_pkg::hcr_sts_t sts,
	output hcr_pkg::hcr_cmd_t      cmd
);
	import hcr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B_ROW,
		ST_B_RD,
		ST_B_MUL,
		ST_B_CMP,
		ST_B_M1,
		ST_B_M2,
		ST_B_DS,
		ST_B_DIV,
		ST_B_WR,
		ST_S_MUL,
		ST_S_RD,
		ST_S_LERP,
		ST_S_OUT
	} state_t;

	state_t state_q;
	logic   acc;

	assign in_ready = state_q == ST_IDLE;
	assign acc      = in_valid && in_ready;

	// Commands decoded from the state and the status.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (in_cmd)
						CMD_WRITE_STOP: cmd.stop_wr   = 1'b1;
						CMD_BUILD:      cmd.bld_start = 1'b1;
						CMD_SAMPLE:     cmd.smp_start = 1'b1;
						default: ;
					endcase
				end
			end
			ST_B_ROW: begin
				if (sts.no_stops) begin
					cmd.row_black = 1'b1;
				end else begin
					cmd.stop_rd = 1'b1;
				end
			end
			ST_B_RD:  cmd.stop_rd  = 1'b1;
			ST_B_MUL: cmd.mul_stop = 1'b1;
			ST_B_CMP: begin
				if (sts.hit) begin
					if (sts.j_zero) begin
						cmd.row_first = 1'b1;
					end else begin
						cmd.interp_init = 1'b1;
					end
				end else if (sts.last_stop) begin
					cmd.row_black = 1'b1;
				end else begin
					cmd.next_stop = 1'b1;
				end
			end
			ST_B_M1:  cmd.mul1      = 1'b1;
			ST_B_M2:  cmd.mul2      = 1'b1;
			ST_B_DS:  cmd.div_start = 1'b1;
			ST_B_DIV: cmd.chan_store = sts.div_done;
			ST_B_WR: begin
				cmd.row_write = 1'b1;
				if (sts.last_row) begin
					cmd.mark_built = 1'b1;
				end else begin
					cmd.next_row = 1'b1;
				end
			end
			ST_S_MUL:  cmd.smp_mul  = 1'b1;
			ST_S_RD:   cmd.smp_rd   = 1'b1;
			ST_S_LERP: cmd.lerp     = 1'b1;
			ST_S_OUT:  cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && (in_cmd == CMD_BUILD)) begin
						state_q <= ST_B_ROW;
					end else if (acc && (in_cmd == CMD_SAMPLE)) begin
						state_q <= ST_S_MUL;
					end
				end
				ST_B_ROW: state_q <= sts.no_stops ? ST_B_WR : ST_B_MUL;
				ST_B_RD:  state_q <= ST_B_MUL;
				ST_B_MUL: state_q <= ST_B_CMP;
				ST_B_CMP: begin
					if (sts.hit) begin
						state_q <= sts.j_zero ? ST_B_WR : ST_B_M1;
					end else begin
						state_q <= sts.last_stop ? ST_B_WR : ST_B_RD;
					end
				end
				ST_B_M1: state_q <= ST_B_M2;
				ST_B_M2: state_q <= ST_B_DS;
				ST_B_DS: state_q <= ST_B_DIV;
				ST_B_DIV: begin
					if (sts.div_done) begin
						state_q <= sts.last_chan ? ST_B_WR : ST_B_M1;
					end
				end
				ST_B_WR:  state_q <= sts.last_row ? ST_IDLE : ST_B_ROW;
				ST_S_MUL: state_q <= ST_S_RD;
				ST_S_RD:  state_q <= ST_S_LERP;
				ST_S_LERP: begin
					if (sts.last_chan) begin
						state_q <= ST_S_OUT;
					end
				end
				ST_S_OUT: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result loaded over one not yet taken");
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider finished right after start");
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.bld_start || cmd.smp_start) |=> !in_ready)
		else $error("new request taken while a build or sample runs");
`endif

endmodule
`default_nettype wire

/* src/heatmap_color_ramp_unit.sv */
// Channel   Direction  Handshake               Payload
// in        request    in_valid / in_ready     cmd, stop_index, stop_pos, stop_*, sample_value
// out       result     out_valid / out_ready   red, green, blue
// cfg       write      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A stop write is stored when it is accepted; a sample runs through the scale
// multiply, the registered table read, one blend per color channel and the output load.
// A build visits each table entry in turn: with no stops it writes the entry
// black, else it scans the stops in order, and when it interpolates each color
// channel passes through the shared divider.
// Reset clears control and configuration state only; the stop and table memories
// hold garbage until written. A waiting result stalls only the next sample at its last step.
`default_nettype none
module heatmap_color_ramp_unit #(
	parameter int MAX_STOPS    = 8,
	parameter int TABLE_DEPTH  = 1024,
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [2:0]  stop_index,
	input  wire logic [16:0] stop_pos,
	input  wire logic [15:0] stop_red,
	input  wire logic [15:0] stop_green,
	input  wire logic [15:0] stop_blue,
	input  wire logic [17:0] sample_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      red,
	output logic [15:0]      green,
	output logic [15:0]      blue,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);
	import hcr_pkg::*;

	hcr_cmd_t dp_cmd;
	hcr_sts_t dp_sts;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	hcr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_cmd  (cmd),
		.in_ready(in_ready),
		.sts     (dp_sts),
		.cmd     (dp_cmd)
	);

	hcr_datapath #(
		.MAX_STOPS   (MAX_STOPS),
		.TABLE_DEPTH (TABLE_DEPTH),
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.stop_index  (stop_index),
		.stop_pos    (stop_pos),
		.stop_red    (stop_red),
		.stop_green  (stop_green),
		.stop_blue   (stop_blue),
		.sample_value(sample_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

endmodule
`default_nettype wire

/* tb/heatmap_color_ramp_checker.sv */
`timescale 1ns / 1ps
module heatmap_color_ramp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [2:0]  stop_index,
	input  wire logic [16:0] stop_pos,
	input  wire logic [15:0] stop_red,
	input  wire logic [15:0] stop_green,
	input  wire logic [15:0] stop_blue,
	input  wire logic [17:0] sample_value,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [15:0] red,
	input  wire logic [15:0] green,
	input  wire logic [15:0] blue,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	output int               fail_count,
	output int               colors_waiting,
	output int               colors_seen,
	output int               tables_built
);
	import hcr_pkg::*;

	localparam int NUM_STOPS = 8;
	localparam int DEPTH     = 1024;

	typedef struct packed {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
	} rgb_t;

	// Shadow of the block: registers, stops, table and build status.
	logic [10:0] res_reg;
	logic [3:0]  count_reg;
	logic [16:0] stop_at [NUM_STOPS];
	rgb_t        stop_rgb [NUM_STOPS];
	rgb_t        ramp [DEPTH];
	int unsigned built_res;
	bit          built;
	rgb_t        expected_colors [$];

	function automatic logic [15:0] chan(rgb_t c, int k);
		return (k == 0) ? c.r : (k == 1) ? c.g : c.b;
	endfunction

	// Fill the table from the stops at the current register settings.
	task automatic rebuild_ramp();
		int unsigned res, n;
		longint unsigned goal, p, q, num, den, a, b, v;
		logic [15:0] ch [3];
		res = (res_reg < 2) ? 2 : (res_reg > DEPTH) ? DEPTH : res_reg;
		n = (count_reg > NUM_STOPS) ? NUM_STOPS : count_reg;
		for (int i = 0; i < res; i++) begin
			goal = longint'(i) * 65536;
			ch = '{16'd0, 16'd0, 16'd0};
			for (int j = 0; j < n; j++) begin
				p = stop_at[j];
				if (p * res >= goal) begin
					if (j == 0) begin
						for (int k = 0; k < 3; k++) ch[k] = chan(stop_rgb[0], k);
					end else begin
						q = stop_at[j-1];
						num = goal - q * res;
						den = (p - q) * res;
						for (int k = 0; k < 3; k++) begin
							a = chan(stop_rgb[j-1], k);
							b = chan(stop_rgb[j], k);
							v = (a * (den - num) + b * num + den / 2) / den;
							ch[k] = v[15:0];
						end
					end
					break;
				end
			end
			ramp[i] = '{ch[0], ch[1], ch[2]};
		end
		built_res = res;
		built = 1;
	endtask

	// Clamp, scale and blend two neighboring table entries.
	function automatic rgb_t shade_sample(logic signed [17:0] raw);
		longint unsigned x, pos, f, a, b, v;
		int unsigned k;
		logic [15:0] ch [3];
		if (!built) return '0;
		if (raw < 0) x = 0;
		else if (raw > 65536) x = 65536;
		else x = raw;
		pos = x * built_res;
		k = 32'(pos >> 16);
		f = pos & 64'hFFFF;
		if (k >= built_res - 1) return ramp[built_res-1];
		for (int c = 0; c < 3; c++) begin
			a = chan(ramp[k], c);
			b = chan(ramp[k+1], c);
			v = (a * (65536 - f) + b * f + 32768) >> 16;
			ch[c] = v[15:0];
		end
		return '{ch[0], ch[1], ch[2]};
	endfunction

	assign colors_waiting = expected_colors.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_reg = RES_RESET;
			count_reg = '0;
			built = 0;
			built_res = 0;
			expected_colors.delete();
			fail_count = 0;
			colors_seen = 0;
			tables_built = 0;
		end else begin
			// Register writes.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TABLE_RES) res_reg = cfg_data;
				else if (cfg_index == REG_STOP_COUNT) count_reg = cfg_data[3:0];
			end
			// Accepted results against the oldest expectation.
			if (out_valid && out_ready) begin
				colors_seen++;
				if (expected_colors.size() == 0) begin
					$error("unexpected color result %h %h %h", red, green, blue);
					fail_count++;
				end else begin
					rgb_t e;
					e = expected_colors.pop_front();
					if (red !== e.r) begin
						$error("red: expected %h, got %h", e.r, red);
						fail_count++;
					end
					if (green !== e.g) begin
						$error("green: expected %h, got %h", e.g, green);
						fail_count++;
					end
					if (blue !== e.b) begin
						$error("blue: expected %h, got %h", e.b, blue);
						fail_count++;
					end
				end
			end
			// Accepted requests update the shadow state.
			if (in_valid && in_ready) begin
				case (cmd)
					CMD_WRITE_STOP: begin
						stop_at[stop_index] = stop_pos;
						stop_rgb[stop_index] = '{stop_red, stop_green, stop_blue};
					end
					CMD_BUILD: begin
						rebuild_ramp();
						tables_built++;
					end
					CMD_SAMPLE: expected_colors = {expected_colors, shade_sample(sample_value)};
					default: ;
				endcase
			end
		end
	end

endmodule

/* tb/heatmap_color_ramp_unit_test.sv */
`timescale 1ns / 1ps
module heatmap_color_ramp_unit_test;
	import hcr_pkg::*;

	localparam longint CYCLE_LIMIT = 3_000_000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [2:0]  stop_index;
	logic [16:0] stop_pos;
	logic [15:0] stop_red, stop_green, stop_blue;
	logic [17:0] sample_value;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] red, green, blue;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	int     fail_count, colors_waiting, colors_seen, tables_built;
	longint cycles;
	int     idle_mode;
	int     hold_cycles;
	int     requests_sent;

	heatmap_color_ramp_unit DUT (.*);

	heatmap_color_ramp_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Timeout guard.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL heatmap_color_ramp_unit");
			$finish;
		end
	end

	// Receiver: a long hold-off when asked, else random stalls per mode.
	initial out_ready = 0;
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else if (idle_mode == 2) out_ready <= ($urandom_range(0, 99) >= 85);
		else if (idle_mode == 3) out_ready <= ($urandom_range(0, 99) >= 13);
		else out_ready <= 1;
	end

	// Offer one request and wait for it to be accepted.
	task automatic send_req(logic [1:0] c, logic [2:0] idx, logic [16:0] p,
			logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [17:0] sv);
		int gap;
		gap = 0;
		if (idle_mode == 1 && $urandom_range(0, 99) < 85) gap = $urandom_range(1, 6);
		else if (idle_mode == 3 && $urandom_range(0, 99) < 13) gap = $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		stop_index <= idx;
		stop_pos <= p;
		stop_red <= r;
		stop_green <= g;
		stop_blue <= b;
		sample_value <= sv;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		requests_sent++;
	endtask

	task automatic color_req(logic [17:0] sv);
		send_req(CMD_SAMPLE, '0, '0, '0, '0, '0, sv);
	endtask

	task automatic stop_req(logic [2:0] idx, logic [16:0] p,
			logic [15:0] r, logic [15:0] g, logic [15:0] b);
		send_req(CMD_WRITE_STOP, idx, p, r, g, b, '0);
	endtask

	// Wait until every expected color is back and the block has gone quiet.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (colors_waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write both registers back to back, valid held high between them.
	task automatic set_ramp(logic [10:0] res, logic [10:0] count);
		cfg_valid <= 1;
		cfg_index <= REG_TABLE_RES;
		cfg_data <= res;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_index <= REG_STOP_COUNT;
		cfg_data <= count;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 0;
	endtask

	task automatic random_stop();
		logic [16:0] p;
		p = ($urandom_range(0, 1)) ? 17'($urandom_range(0, 65536)) : 17'($urandom);
		stop_req(3'($urandom), p, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic random_color();
		if ($urandom_range(0, 9) < 7) color_req(18'($urandom_range(0, 65536)));
		else color_req(18'($urandom));
	endtask

	// One random phase; tables of large size, and a resolution of zero, are built only once.
	task automatic run_phase(int res, int count, int mode, int n_items, int hold);
		int pick;
		bit big;
		set_ramp(11'(res), 11'(count));
		idle_mode = mode;
		big = (res > 64 || res == 0);
		if (big) send_req(CMD_BUILD, '0, '0, '0, '0, '0, '0);
		if (hold > 0) hold_cycles = hold;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (big) begin
				if (pick < 15) random_stop();
				else random_color();
			end else if (pick < 28) random_stop();
			else if (pick < 36) send_req(CMD_BUILD, '0, '0, '0, '0, '0, '0);
			else if (pick < 98) random_color();
			else send_req(2'd3, 3'($urandom), 17'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 18'($urandom));
		end
		// A final sample returns only after any build ahead of it is done.
		random_color();
		drain();
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		cmd = CMD_WRITE_STOP;
		stop_index = '0;
		stop_pos = '0;
		stop_red = '0;
		stop_green = '0;
		stop_blue = '0;
		sample_value = '0;
		cfg_valid = 0;
		cfg_index = REG_TABLE_RES;
		cfg_data = '0;
		idle_mode = 0;
		hold_cycles = 0;
		requests_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: samples before any build come back black.
		color_req(18'd0);
		color_req(18'h3FFFF);
		drain();
		set_ramp(11'd4, 11'd8);
		// Every stop slot gets written before the first build.
		stop_req(3'd0, 17'd0, 16'hFFFF, 16'h0000, 16'h0000);
		stop_req(3'd1, 17'd16384, 16'h0000, 16'hFFFF, 16'h0000);
		stop_req(3'd2, 17'd8192, 16'h0000, 16'h0000, 16'hFFFF);
		stop_req(3'd3, 17'd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		stop_req(3'd4, 17'd65536, 16'h1234, 16'h0000, 16'hFFFF);
		stop_req(3'd5, 17'd131071, 16'h0000, 16'h0000, 16'h0000);
		stop_req(3'd6, 17'd65536, 16'hAAAA, 16'h5555, 16'h8000);
		stop_req(3'd7, 17'd100000, 16'h7FFF, 16'h0001, 16'hFFFE);
		send_req(CMD_BUILD, '0, '0, '0, '0, '0, '0);
		color_req(18'h20000);
		color_req(18'd0);
		color_req(18'd1);
		color_req(18'd32768);
		color_req(18'd65535);
		color_req(18'd65536);
		color_req(18'd65537);
		color_req(18'h1FFFF);
		send_req(2'd3, 3'd7, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF);
		drain();
		// A new resolution without a build leaves sampling unchanged.
		set_ramp(11'd8, 11'd3);
		color_req(18'd40000);
		send_req(CMD_BUILD, '0, '0, '0, '0, '0, '0);
		color_req(18'd40000);
		drain();

		// Random phases across register extremes and idling patterns.
		run_phase(0, 8, 0, 55, 0);
		run_phase(3, 15, 1, 55, 0);
		run_phase(16, 0, 0, 55, 300);
		run_phase(2, 1, 2, 55, 0);
		run_phase(33, 8, 3, 55, 0);
		run_phase(1024, 8, 0, 45, 0);
		run_phase(2047, 5, 3, 45, 0);
		run_phase(1, 2, 2, 55, 0);
		run_phase(100, 7, 1, 55, 0);

		repeat (50) @(posedge clk);
		$display("Sent %0d requests, built %0d tables, checked %0d colors.",
			requests_sent, tables_built, colors_seen);
		$display("Covered resolutions from 0 to 2047, stop counts 0 to 15, and stalls.");
		if (fail_count == 0) $display("PASS heatmap_color_ramp_unit");
		else $display("FAIL heatmap_color_ramp_unit");
		$finish;
	end

endmodule

/* filelist.f */
src/hcr_pkg.sv
src/hcr_divider.sv
src/hcr_datapath.sv
src/hcr_ctrl.sv
src/heatmap_color_ramp_unit.sv
tb/heatmap_color_ramp_checker.sv
tb/heatmap_color_ramp_unit_test.sv
